@@ rtl/tmcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

    // field widths
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;
    localparam int CODE_W   = 9;
    localparam int INDEX_W  = 11;
    localparam int ATTR_W   = 8;
    localparam int CHAR_W   = 8;

    // attribute after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // character codes
    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'h00a;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
    localparam logic [CODE_W-1:0] CODE_LEFT      = 9'h101;
    localparam logic [CODE_W-1:0] CODE_RIGHT     = 9'h102;
    localparam logic [CODE_W-1:0] CODE_UP        = 9'h103;
    localparam logic [CODE_W-1:0] CODE_DOWN      = 9'h104;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;

    // function codes
    localparam logic FUNC_READ = 1'b1;

    // microprogram step addresses
    typedef enum logic [3:0] {
        STEP_CLEAR    = 4'd0,
        STEP_IDLE     = 4'd1,
        STEP_DISPATCH = 4'd2,
        STEP_MOVE     = 4'd3,
        STEP_CHECK    = 4'd4,
        STEP_SHIFT    = 4'd5,
        STEP_ZERO     = 4'd6,
        STEP_UNROLL   = 4'd7,
        STEP_BLANK    = 4'd8,
        STEP_READOUT  = 4'd9
    } step_t;

    // branch conditions: taken goes to target, otherwise next step
    typedef enum logic [2:0] {
        COND_NEXT           = 3'd0,
        COND_ALWAYS         = 3'd1,
        COND_NO_START       = 3'd2,
        COND_IS_READ        = 3'd3,
        COND_NO_SCROLL      = 3'd4,
        COND_PTR_NOT_LAST   = 3'd5,
        COND_PTR_NOT_SHIFTN = 3'd6
    } cond_t;

    typedef enum logic [2:0] {
        MEM_NONE     = 3'd0,
        MEM_WR_ZERO  = 3'd1,
        MEM_WR_CHAR  = 3'd2,
        MEM_WR_BLANK = 3'd3,
        MEM_WR_COPY  = 3'd4
    } mem_op_t;

    typedef enum logic [1:0] {
        RD_NONE      = 2'd0,
        RD_INDEX     = 2'd1,
        RD_ROW_AHEAD = 2'd2,
        RD_ROW_NEXT  = 2'd3
    } rd_op_t;

    typedef enum logic [1:0] {
        CUR_HOLD    = 2'd0,
        CUR_MOTION  = 2'd1,
        CUR_SUB_ROW = 2'd2
    } cur_op_t;

    typedef enum logic [1:0] {
        PTR_HOLD  = 2'd0,
        PTR_CLEAR = 2'd1,
        PTR_INC   = 2'd2
    } ptr_op_t;

    // one control word of the microprogram
    typedef struct packed {
        cond_t   cond;
        step_t   target;
        logic    busy;
        logic    latch;
        logic    done;
        mem_op_t mem_op;
        rd_op_t  rd_op;
        cur_op_t cur_op;
        ptr_op_t ptr_op;
    } ctrl_word_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic is_read;
        logic scroll;
        logic ptr_last;
        logic ptr_shift_last;
    } status_t;

    // control store
    function automatic ctrl_word_t ucode(input step_t s);
        ctrl_word_t w;
        w        = '0;
        w.cond   = COND_NEXT;
        w.target = STEP_IDLE;
        w.busy   = 1'b1;
        case (s)
            STEP_CLEAR:
            begin
                w.cond   = COND_PTR_NOT_LAST;
                w.target = STEP_CLEAR;
                w.mem_op = MEM_WR_ZERO;
                w.ptr_op = PTR_INC;
            end
            STEP_IDLE:
            begin
                w.cond   = COND_NO_START;
                w.target = STEP_IDLE;
                w.busy   = 1'b0;
                w.latch  = 1'b1;
            end
            STEP_DISPATCH:
            begin
                w.cond   = COND_IS_READ;
                w.target = STEP_READOUT;
                w.rd_op  = RD_INDEX;
            end
            STEP_MOVE:
            begin
                w.mem_op = MEM_WR_CHAR;
                w.cur_op = CUR_MOTION;
                w.ptr_op = PTR_CLEAR;
            end
            STEP_CHECK:
            begin
                w.cond   = COND_NO_SCROLL;
                w.target = STEP_BLANK;
                w.rd_op  = RD_ROW_AHEAD;
            end
            STEP_SHIFT:
            begin
                w.cond   = COND_PTR_NOT_SHIFTN;
                w.target = STEP_SHIFT;
                w.mem_op = MEM_WR_COPY;
                w.rd_op  = RD_ROW_NEXT;
                w.ptr_op = PTR_INC;
            end
            STEP_ZERO:
            begin
                w.cond   = COND_PTR_NOT_LAST;
                w.target = STEP_ZERO;
                w.mem_op = MEM_WR_ZERO;
                w.ptr_op = PTR_INC;
            end
            STEP_UNROLL:
            begin
                w.cur_op = CUR_SUB_ROW;
            end
            STEP_BLANK:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
                w.mem_op = MEM_WR_BLANK;
                w.done   = 1'b1;
            end
            STEP_READOUT:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
                w.done   = 1'b1;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tmcw_useq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tmcw_useq (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  tmcw_pkg::status_t        status,
    output tmcw_pkg::ctrl_word_t     cw,
    output logic                     busy
);

    tmcw_pkg::step_t upc_reg;
    tmcw_pkg::step_t upc_next;
    logic            taken;

    // step counter, starts with the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= tmcw_pkg::STEP_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // branch evaluation and next step
    always_comb
    begin
        case (cw.cond)
            tmcw_pkg::COND_NEXT:           taken = 1'b0;
            tmcw_pkg::COND_ALWAYS:         taken = 1'b1;
            tmcw_pkg::COND_NO_START:       taken = !start;
            tmcw_pkg::COND_IS_READ:        taken = status.is_read;
            tmcw_pkg::COND_NO_SCROLL:      taken = !status.scroll;
            tmcw_pkg::COND_PTR_NOT_LAST:   taken = !status.ptr_last;
            tmcw_pkg::COND_PTR_NOT_SHIFTN: taken = !status.ptr_shift_last;
            default:                       taken = 1'b1;
        endcase
        if (taken)
        begin
            upc_next = cw.target;
        end
        else
        begin
            upc_next = tmcw_pkg::step_t'(upc_reg + 4'd1);
        end
    end

    // control word lookup
    always_comb
    begin
        cw   = tmcw_pkg::ucode(upc_reg);
        busy = cw.busy;
    end

endmodule

`default_nettype wire

@@ rtl/tmcw_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tmcw_datapath #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROWS = 24
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    input  wire                                  func,
    input  wire  [tmcw_pkg::CODE_W-1:0]          char_code,
    input  wire  [tmcw_pkg::INDEX_W-1:0]         cell_index,
    input  wire                                  cfg_write,
    input  wire  [tmcw_pkg::ATTR_W-1:0]          cfg_data,
    input  tmcw_pkg::ctrl_word_t                 cw,
    output tmcw_pkg::status_t                    status,
    output logic                                 done,
    output logic [tmcw_pkg::CURSOR_W-1:0]        cursor_position,
    output logic [tmcw_pkg::CELL_W-1:0]          cell_value
);

    localparam int CELLS = COLUMNS * SCROLL_ROWS;
    localparam int AW    = $clog2(CELLS + 1);
    localparam int MW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] CELLS_A      = AW'(CELLS);
    localparam logic [AW-1:0] COLS_A       = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_A       = AW'(CELLS - 1);
    localparam logic [AW-1:0] SHIFT_LAST_A = AW'((SCROLL_ROWS - 1) * COLUMNS - 1);
    localparam logic [CW-1:0] COL_LAST     = CW'(COLUMNS - 1);

    logic [tmcw_pkg::ATTR_W-1:0]   attr_reg;
    logic                          func_reg;
    logic [tmcw_pkg::CODE_W-1:0]   code_reg;
    logic [tmcw_pkg::INDEX_W-1:0]  idx_reg;
    logic [AW-1:0]                 cur_reg;
    logic [AW-1:0]                 cur_next;
    logic [CW-1:0]                 col_reg;
    logic [CW-1:0]                 col_next;
    logic [AW-1:0]                 ptr_reg;
    logic [AW-1:0]                 ptr_next;
    logic [tmcw_pkg::CELL_W-1:0]   rdata_reg;
    logic                          done_reg;
    logic [tmcw_pkg::CURSOR_W-1:0] cursor_position_reg;
    logic [tmcw_pkg::CELL_W-1:0]   cell_value_reg;

    logic [tmcw_pkg::CELL_W-1:0]   mem [0:CELLS-1];

    logic                          is_newline;
    logic                          is_back;
    logic                          is_left;
    logic                          is_right;
    logic                          is_still;
    logic                          is_print;
    logic                          idx_in_range;
    logic                          is_read;

    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [tmcw_pkg::CELL_W-1:0]   wdata;
    logic                          rd_en;
    logic [AW-1:0]                 raddr;

    // attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tmcw_pkg::ATTR_RESET;
        end
        else if (cfg_write)
        begin
            attr_reg <= cfg_data;
        end
    end

    // capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cw.latch && start)
        begin
            func_reg <= func;
            code_reg <= char_code;
            idx_reg  <= cell_index;
        end
    end

    // code classes
    always_comb
    begin
        is_newline   = (code_reg == tmcw_pkg::CODE_NEWLINE);
        is_left      = (code_reg == tmcw_pkg::CODE_LEFT);
        is_right     = (code_reg == tmcw_pkg::CODE_RIGHT);
        is_back      = (code_reg == tmcw_pkg::CODE_BACKSPACE) || is_left;
        is_still     = (code_reg == tmcw_pkg::CODE_UP) || (code_reg == tmcw_pkg::CODE_DOWN);
        is_print     = !(is_newline || is_back || is_right || is_still);
        idx_in_range = (32'(idx_reg) < 32'(CELLS));
        is_read      = (func_reg == tmcw_pkg::FUNC_READ);
    end

    // cursor and column motion
    always_comb
    begin
        cur_next = cur_reg;
        col_next = col_reg;
        case (cw.cur_op)
            tmcw_pkg::CUR_MOTION:
            begin
                if (is_newline)
                begin
                    cur_next = cur_reg + (COLS_A - AW'(col_reg));
                    col_next = '0;
                end
                else if (is_back)
                begin
                    if (cur_reg != '0)
                    begin
                        cur_next = cur_reg - AW'(1);
                        col_next = (col_reg == '0) ? COL_LAST : col_reg - CW'(1);
                    end
                end
                else if (!is_still)
                begin
                    cur_next = cur_reg + AW'(1);
                    col_next = (col_reg == COL_LAST) ? '0 : col_reg + CW'(1);
                end
            end
            tmcw_pkg::CUR_SUB_ROW:
            begin
                cur_next = cur_reg - COLS_A;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // scan pointer
    always_comb
    begin
        case (cw.ptr_op)
            tmcw_pkg::PTR_CLEAR: ptr_next = '0;
            tmcw_pkg::PTR_INC:   ptr_next = ptr_reg + AW'(1);
            default:             ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            col_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
            col_reg <= col_next;
            ptr_reg <= ptr_next;
        end
    end

    // cell store write port
    always_comb
    begin
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = '0;
        case (cw.mem_op)
            tmcw_pkg::MEM_WR_ZERO:
            begin
                we = 1'b1;
            end
            tmcw_pkg::MEM_WR_CHAR:
            begin
                we    = is_print;
                waddr = cur_reg;
                wdata = {attr_reg, code_reg[tmcw_pkg::CHAR_W-1:0]};
            end
            tmcw_pkg::MEM_WR_BLANK:
            begin
                we    = !(is_left || is_right);
                waddr = cur_reg;
                wdata = {attr_reg, tmcw_pkg::BLANK_CHAR};
            end
            tmcw_pkg::MEM_WR_COPY:
            begin
                we    = 1'b1;
                wdata = rdata_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // cell store read port, reads past the store are dropped
    always_comb
    begin
        case (cw.rd_op)
            tmcw_pkg::RD_INDEX:
            begin
                raddr = AW'(idx_reg);
                rd_en = idx_in_range;
            end
            tmcw_pkg::RD_ROW_AHEAD:
            begin
                raddr = ptr_reg + COLS_A;
                rd_en = (raddr < CELLS_A);
            end
            tmcw_pkg::RD_ROW_NEXT:
            begin
                raddr = ptr_reg + COLS_A + AW'(1);
                rd_en = (raddr < CELLS_A);
            end
            default:
            begin
                raddr = ptr_reg;
                rd_en = 1'b0;
            end
        endcase
    end

    // cell store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr[MW-1:0]] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr[MW-1:0]];
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cw.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.done)
        begin
            cursor_position_reg <= tmcw_pkg::CURSOR_W'(cur_reg);
            cell_value_reg      <= (is_read && idx_in_range) ? rdata_reg : '0;
        end
    end

    // flags for the sequencer
    always_comb
    begin
        status.is_read        = is_read;
        status.scroll         = (cur_reg >= CELLS_A);
        status.ptr_last       = (ptr_reg == LAST_A);
        status.ptr_shift_last = (ptr_reg == SHIFT_LAST_A);
    end

    assign done            = done_reg;
    assign cursor_position = cursor_position_reg;
    assign cell_value      = cell_value_reg;

endmodule

`default_nettype wire

@@ rtl/text_mode_cell_writer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// text-mode screen writer: a transaction is taken when start is high and busy is low, and
// its one result appears on cursor_position and cell_value, marked by done for a single
// cycle, which the receiver cannot hold off. the result shows in the same cycle that busy
// drops; a put that scrolls shifts the rows up through the single write port of the cell
// store, which moves one cell per cycle, then zeroes the last row. after reset the block
// runs a clearing pass over the COLUMNS*SCROLL_ROWS cells with busy high. the attribute
// register takes a write whenever cfg_valid is high and should be written only while no
// transaction is in progress.
module text_mode_cell_writer_core #(
    parameter int COLUMNS     = 80,
    parameter int SCROLL_ROWS = 24
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              func,
    input  wire  [tmcw_pkg::CODE_W-1:0]      char_code,
    input  wire  [tmcw_pkg::INDEX_W-1:0]     cell_index,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [tmcw_pkg::ATTR_W-1:0]      cfg_data,
    output logic                             done,
    output logic [tmcw_pkg::CURSOR_W-1:0]    cursor_position,
    output logic [tmcw_pkg::CELL_W-1:0]      cell_value
);

    tmcw_pkg::ctrl_word_t cw;
    tmcw_pkg::status_t    status;

    // configuration is always accepted
    assign cfg_ready = 1'b1;

    // microprogram sequencer
    tmcw_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cw     (cw),
        .busy   (busy)
    );

    // cursor, scan pointer and cell store
    tmcw_datapath #(
        .COLUMNS     (COLUMNS),
        .SCROLL_ROWS (SCROLL_ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .func            (func),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .cw              (cw),
        .status          (status),
        .done            (done),
        .cursor_position (cursor_position),
        .cell_value      (cell_value)
    );

endmodule

`default_nettype wire

@@ rtl/tmcw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tmcw_checker (
    input wire clk,
    input wire rst_n,
    input wire start,
    input wire busy,
    input wire done
);

    // busy during reset, the clearing pass follows
    a_busy_in_reset: assert property (@(posedge clk) !rst_n |-> busy)
        else $error("busy low during reset");

    // an accepted transaction makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // no result in the cycle right after an accept
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too early after accept");

    // a result strobe lasts one cycle and the block is ready by then
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy ##1 !done)
        else $error("result strobe malformed");

endmodule

bind text_mode_cell_writer_core tmcw_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
